// ----- hw/rtl/ezmc_pkg.sv -----
// Shared types, constants and helper functions for the ZXZ Euler / matrix converter.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package ezmc_pkg;

    localparam int WF       = 30;   // internal fraction bits
    localparam int LW       = 36;   // lane datapath width
    localparam int AMW      = 33;   // widest angle field carried as echo
    localparam int SQ_STEPS = 31;   // root bits of floor_sqrt(2^60 - c^2)
    localparam int SQ_RW    = 62;
    localparam int SQ_QW    = 31;

    typedef logic signed [LW-1:0] t_q;

    localparam t_q PI_Q      = 36'sd3373259426;
    localparam t_q HALF_PI_Q = 36'sd1686629713;
    localparam t_q GAIN_Q    = 36'sd652032874;

    typedef enum logic [1:0] {
        OFF_NONE,
        OFF_PLUS_PI,
        OFF_MINUS_PI
    } t_off;

    typedef struct packed {
        logic rot;      // 1: sin/cos rotation, 0: atan2 vectoring
        logic neg;      // negate x,y at the end
        logic zero;     // atan2 of the zero vector
        t_off off;
    } t_lane_ctl;

    typedef struct packed {
        t_q        x;
        t_q        y;
        t_q        z;
        t_lane_ctl ctl;
    } t_lane;

    typedef struct packed {
        logic                  kind;
        logic                  degen;
        logic signed [AMW-1:0] a0;
        logic signed [AMW-1:0] a1;
        logic signed [AMW-1:0] a2;
    } t_side;

    typedef struct packed {
        t_side             side;
        t_lane [2:0]       lane;
        logic [SQ_RW-1:0]  rem;
        logic [SQ_QW-1:0]  root;
        logic signed [31:0] c;
    } t_sq;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'hC90FDAA2, 32'h76B19C16, 32'h3EB6EBF2, 32'h1FD5BA9B,
        32'h0FFAADDC, 32'h07FF556F, 32'h03FFEAAB, 32'h01FFFD55,
        32'h00FFFFAB, 32'h007FFFF5, 32'h003FFFFF, 32'h00200000,
        32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000,
        32'h00010000, 32'h00008000, 32'h00004000, 32'h00002000,
        32'h00001000, 32'h00000800, 32'h00000400, 32'h00000200,
        32'h00000100, 32'h00000080, 32'h00000040, 32'h00000020,
        32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002
    };

    // atan(2^-i) rounded from Q0.32 to Q30
    function automatic t_q atan_step(input logic [4:0] i);
        logic [33:0] v;
        v = ({2'b00, ATAN_TAB[i]} + 34'd2) >> 2;
        return t_q'({2'b00, v});
    endfunction

    function automatic t_lane sincos_setup(input t_q th);
        t_lane l;
        l.x        = GAIN_Q;
        l.y        = '0;
        l.z        = th;
        l.ctl.rot  = 1'b1;
        l.ctl.neg  = 1'b0;
        l.ctl.zero = 1'b0;
        l.ctl.off  = OFF_NONE;
        if (th > HALF_PI_Q) begin
            l.z       = th - PI_Q;
            l.ctl.neg = 1'b1;
        end else if (th < -HALF_PI_Q) begin
            l.z       = th + PI_Q;
            l.ctl.neg = 1'b1;
        end
        return l;
    endfunction

    function automatic t_lane atan2_setup(input t_q y, input t_q x);
        t_lane l;
        l.x        = x;
        l.y        = y;
        l.z        = '0;
        l.ctl.rot  = 1'b0;
        l.ctl.neg  = 1'b0;
        l.ctl.zero = (x == '0) && (y == '0);
        l.ctl.off  = OFF_NONE;
        if (x < 0) begin
            l.ctl.off = (y >= 0) ? OFF_PLUS_PI : OFF_MINUS_PI;
            l.x       = -x;
            l.y       = -y;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ezmc_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cycle while i_en is high.
// Depends on ezmc_pkg; carries the rest of the transaction alongside.
`timescale 1ns / 1ps
`default_nettype none

module ezmc_sqrt_cell import ezmc_pkg::*; #(
    parameter int BIT = 0
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_en,
    input  wire  i_valid,
    input  t_sq  i_item,
    output logic o_valid,
    output t_sq  o_item
);

    logic             r_valid;
    t_sq              r_item;
    t_sq              n_item;
    logic [SQ_RW-1:0] w_trial;

    // (root + 2^b)^2 - root^2
    assign w_trial = (SQ_RW'(i_item.root) << (BIT + 1)) + (SQ_RW'(1) << (2 * BIT));

    always_comb begin
        n_item = i_item;
        if (i_item.rem >= w_trial) begin
            n_item.rem  = i_item.rem - w_trial;
            n_item.root = i_item.root | (SQ_QW'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- hw/rtl/ezmc_cordic_cell.sv -----
// One CORDIC iteration for all three lanes, rotation or vectoring per lane.
// Depends on ezmc_pkg for lane types and the arctangent steps.
`timescale 1ns / 1ps
`default_nettype none

module ezmc_cordic_cell import ezmc_pkg::*; #(
    parameter int STEP = 0
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  t_lane [2:0] i_lane,
    input  t_side       i_side,
    output logic        o_valid,
    output t_lane [2:0] o_lane,
    output t_side       o_side
);

    logic        r_valid;
    t_lane [2:0] r_lane;
    t_side       r_side;
    t_lane [2:0] n_lane;
    t_q          w_step;

    assign w_step = atan_step(5'(STEP));

    always_comb begin
        logic pos;
        n_lane = i_lane;
        for (int k = 0; k < 3; k++) begin
            pos = i_lane[k].ctl.rot ? (i_lane[k].z >= 0) : (i_lane[k].y < 0);
            if (pos) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z - w_step;
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z + w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ----- hw/rtl/ezmc_back.sv -----
// Back end: finishes the CORDIC lanes, forms the matrix from lane products
// or rounds the angles, and holds the output register. Depends on ezmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ezmc_back import ezmc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_en,
    input  wire                         i_valid,
    input  t_lane [2:0]                 i_lane,
    input  t_side                       i_side,
    output logic                        o_valid,
    output logic signed [FRAC_BITS+1:0] o_r00,
    output logic signed [FRAC_BITS+1:0] o_r01,
    output logic signed [FRAC_BITS+1:0] o_r02,
    output logic signed [FRAC_BITS+1:0] o_r10,
    output logic signed [FRAC_BITS+1:0] o_r11,
    output logic signed [FRAC_BITS+1:0] o_r12,
    output logic signed [FRAC_BITS+1:0] o_r20,
    output logic signed [FRAC_BITS+1:0] o_r21,
    output logic signed [FRAC_BITS+1:0] o_r22,
    output logic signed [FRAC_BITS+2:0] o_out_z1,
    output logic signed [FRAC_BITS+2:0] o_out_x2,
    output logic signed [FRAC_BITS+2:0] o_out_z3
);

    localparam int MW      = FRAC_BITS + 2;
    localparam int AW      = FRAC_BITS + 3;
    localparam int SH      = WF - FRAC_BITS;
    localparam t_q RND     = (t_q'(1) <<< SH) >>> 1;
    localparam t_q MAT_ONE = t_q'(1) <<< FRAC_BITS;
    localparam t_q ANG_HI  = (t_q'(1) <<< (FRAC_BITS + 2)) - t_q'(1);
    localparam t_q ANG_LO  = -(t_q'(1) <<< (FRAC_BITS + 2));

    function automatic t_q mulq(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + 64'sd536870912;
        return t_q'(p >>> WF);
    endfunction

    function automatic logic signed [MW-1:0] to_mat(input t_q v);
        t_q r;
        r = (v + RND) >>> SH;
        if (r < -MAT_ONE) r = -MAT_ONE;
        if (r > MAT_ONE)  r = MAT_ONE;
        return MW'(r);
    endfunction

    function automatic logic signed [AW-1:0] to_ang(input t_q v);
        t_q r;
        r = (v + RND) >>> SH;
        if (r < ANG_LO) r = ANG_LO;
        if (r > ANG_HI) r = ANG_HI;
        return AW'(r);
    endfunction

    // stage 0: lane finish
    logic               r_b0_valid;
    t_side              r_b0_side;
    logic signed [31:0] r_b0_c [3];
    logic signed [31:0] r_b0_s [3];
    t_q                 r_b0_a [3];
    logic signed [31:0] n_b0_c [3];
    logic signed [31:0] n_b0_s [3];
    t_q                 n_b0_a [3];

    always_comb begin
        t_q vx;
        t_q vy;
        t_q off;
        for (int k = 0; k < 3; k++) begin
            vx = i_lane[k].ctl.neg ? -i_lane[k].x : i_lane[k].x;
            vy = i_lane[k].ctl.neg ? -i_lane[k].y : i_lane[k].y;
            unique case (i_lane[k].ctl.off)
                OFF_PLUS_PI:  off = PI_Q;
                OFF_MINUS_PI: off = -PI_Q;
                default:      off = '0;
            endcase
            n_b0_c[k] = vx[31:0];
            n_b0_s[k] = vy[31:0];
            n_b0_a[k] = i_lane[k].ctl.zero ? '0 : i_lane[k].z + off;
        end
    end

    // stage 1: first products, angle rounding
    logic               r_b1_valid;
    t_side              r_b1_side;
    t_q r_b1_c2s3, r_b1_c2c3, r_b1_c1c3, r_b1_c1s3, r_b1_s1s2;
    t_q r_b1_s1c3, r_b1_s1s3, r_b1_c1s2, r_b1_s2s3, r_b1_s2c3;
    logic signed [31:0] r_b1_c1, r_b1_s1, r_b1_c2;
    logic signed [AW-1:0] r_b1_ang [3];

    // stage 2: second products
    logic               r_b2_valid;
    t_side              r_b2_side;
    t_q r_b2_s1c2s3, r_b2_s1c2c3, r_b2_c1c2s3, r_b2_c1c2c3;
    t_q r_b2_c1c3, r_b2_c1s3, r_b2_s1s2, r_b2_s1c3, r_b2_s1s3;
    t_q r_b2_c1s2, r_b2_s2s3, r_b2_s2c3;
    logic signed [31:0] r_b2_c2;
    logic signed [AW-1:0] r_b2_ang [3];

    // output register
    logic                 r_o_valid;
    logic                 r_o_kind;
    logic                 r_o_degen;
    logic signed [MW-1:0] r_o_mat [9];
    logic signed [AW-1:0] r_o_ang [3];
    logic signed [MW-1:0] n_o_mat [9];
    logic signed [AW-1:0] n_o_ang [3];

    always_comb begin
        n_o_mat[0] = to_mat(r_b2_c1c3 - r_b2_s1c2s3);
        n_o_mat[1] = to_mat(-r_b2_c1s3 - r_b2_s1c2c3);
        n_o_mat[2] = to_mat(r_b2_s1s2);
        n_o_mat[3] = to_mat(r_b2_s1c3 + r_b2_c1c2s3);
        n_o_mat[4] = to_mat(r_b2_c1c2c3 - r_b2_s1s3);
        n_o_mat[5] = to_mat(-r_b2_c1s2);
        n_o_mat[6] = to_mat(r_b2_s2s3);
        n_o_mat[7] = to_mat(r_b2_s2c3);
        n_o_mat[8] = to_mat(t_q'(r_b2_c2));
        if (r_b2_side.kind) begin
            for (int k = 0; k < 9; k++) begin
                n_o_mat[k] = '0;
            end
            n_o_ang[0] = r_b2_ang[0];
            n_o_ang[1] = r_b2_side.degen ? '0 : r_b2_ang[1];
            n_o_ang[2] = r_b2_side.degen ? '0 : r_b2_ang[2];
        end else begin
            n_o_ang[0] = AW'(r_b2_side.a0);
            n_o_ang[1] = AW'(r_b2_side.a1);
            n_o_ang[2] = AW'(r_b2_side.a2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid <= 1'b0;
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (i_en) begin
            r_b0_valid <= i_valid;
            r_b1_valid <= r_b0_valid;
            r_b2_valid <= r_b1_valid;
            r_o_valid  <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b0_side <= i_side;
            r_b0_c    <= n_b0_c;
            r_b0_s    <= n_b0_s;
            r_b0_a    <= n_b0_a;

            r_b1_side <= r_b0_side;
            r_b1_c2s3 <= mulq(r_b0_c[1], r_b0_s[2]);
            r_b1_c2c3 <= mulq(r_b0_c[1], r_b0_c[2]);
            r_b1_c1c3 <= mulq(r_b0_c[0], r_b0_c[2]);
            r_b1_c1s3 <= mulq(r_b0_c[0], r_b0_s[2]);
            r_b1_s1s2 <= mulq(r_b0_s[0], r_b0_s[1]);
            r_b1_s1c3 <= mulq(r_b0_s[0], r_b0_c[2]);
            r_b1_s1s3 <= mulq(r_b0_s[0], r_b0_s[2]);
            r_b1_c1s2 <= mulq(r_b0_c[0], r_b0_s[1]);
            r_b1_s2s3 <= mulq(r_b0_s[1], r_b0_s[2]);
            r_b1_s2c3 <= mulq(r_b0_s[1], r_b0_c[2]);
            r_b1_c1   <= r_b0_c[0];
            r_b1_s1   <= r_b0_s[0];
            r_b1_c2   <= r_b0_c[1];
            for (int k = 0; k < 3; k++) begin
                r_b1_ang[k] <= to_ang(r_b0_a[k]);
            end

            r_b2_side   <= r_b1_side;
            r_b2_s1c2s3 <= mulq(r_b1_s1, signed'(r_b1_c2s3[31:0]));
            r_b2_s1c2c3 <= mulq(r_b1_s1, signed'(r_b1_c2c3[31:0]));
            r_b2_c1c2s3 <= mulq(r_b1_c1, signed'(r_b1_c2s3[31:0]));
            r_b2_c1c2c3 <= mulq(r_b1_c1, signed'(r_b1_c2c3[31:0]));
            r_b2_c1c3   <= r_b1_c1c3;
            r_b2_c1s3   <= r_b1_c1s3;
            r_b2_s1s2   <= r_b1_s1s2;
            r_b2_s1c3   <= r_b1_s1c3;
            r_b2_s1s3   <= r_b1_s1s3;
            r_b2_c1s2   <= r_b1_c1s2;
            r_b2_s2s3   <= r_b1_s2s3;
            r_b2_s2c3   <= r_b1_s2c3;
            r_b2_c2     <= r_b1_c2;
            r_b2_ang    <= r_b1_ang;

            r_o_kind  <= r_b2_side.kind;
            r_o_degen <= r_b2_side.degen;
            r_o_mat   <= n_o_mat;
            r_o_ang   <= n_o_ang;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_r00    = r_o_mat[0];
    assign o_r01    = r_o_mat[1];
    assign o_r02    = r_o_mat[2];
    assign o_r10    = r_o_mat[3];
    assign o_r11    = r_o_mat[4];
    assign o_r12    = r_o_mat[5];
    assign o_r20    = r_o_mat[6];
    assign o_r21    = r_o_mat[7];
    assign o_r22    = r_o_mat[8];
    assign o_out_z1 = r_o_ang[0];
    assign o_out_x2 = r_o_ang[1];
    assign o_out_z3 = r_o_ang[2];

    a_kind1_zero_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind) |-> (r_o_mat[0] == '0 && r_o_mat[4] == '0 &&
                                      r_o_mat[8] == '0 && r_o_mat[2] == '0))
        else $error("matrix fields nonzero on a matrix-to-angle result");

    a_degen_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind && r_o_degen) |-> (r_o_ang[1] == '0 && r_o_ang[2] == '0))
        else $error("degenerate result carries nonzero x2 or z3");

    a_hold_when_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> (r_o_valid == $past(r_o_valid) && r_b2_valid == $past(r_b2_valid)))
        else $error("back-end pipeline moved while frozen");

endmodule

`default_nettype wire

// ----- hw/rtl/euler_zxz_matrix_convert_unit.sv -----
// ZXZ Euler angle <-> rotation matrix converter, top level.
// Depends on ezmc_pkg, ezmc_sqrt_cell, ezmc_cordic_cell and ezmc_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one transaction: i_kind
//   selects angles-to-matrix (0) or matrix-to-angles (1). Output channel
//   (o_out_valid / i_out_stall) returns one result per input transaction.
//   Config: i_cfg_valid / o_cfg_ready writes gimbal_threshold (always ready).
// Timing:
//   One input stage, 31 square-root cells (one root bit each), one lane
//   setup stage, one CORDIC cell per iteration and four back-end stages
//   (finish, two multiply levels, output register). One transaction per
//   cycle is accepted while the output is not stalled.
// Reset: synchronous, active low; clears all valid bits and the threshold.
// Backpressure: when the output register holds a result and i_out_stall is
//   high the whole pipeline freezes and o_in_stall is raised in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module euler_zxz_matrix_convert_unit import ezmc_pkg::*; #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_kind,
    input  wire  signed [FRAC_BITS+2:0]  i_in_z1,
    input  wire  signed [FRAC_BITS+2:0]  i_in_x2,
    input  wire  signed [FRAC_BITS+2:0]  i_in_z3,
    input  wire  signed [FRAC_BITS+1:0]  i_m02,
    input  wire  signed [FRAC_BITS+1:0]  i_m10,
    input  wire  signed [FRAC_BITS+1:0]  i_m11,
    input  wire  signed [FRAC_BITS+1:0]  i_m12,
    input  wire  signed [FRAC_BITS+1:0]  i_m20,
    input  wire  signed [FRAC_BITS+1:0]  i_m21,
    input  wire  signed [FRAC_BITS+1:0]  i_m22,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic signed [FRAC_BITS+1:0]  o_r00,
    output logic signed [FRAC_BITS+1:0]  o_r01,
    output logic signed [FRAC_BITS+1:0]  o_r02,
    output logic signed [FRAC_BITS+1:0]  o_r10,
    output logic signed [FRAC_BITS+1:0]  o_r11,
    output logic signed [FRAC_BITS+1:0]  o_r12,
    output logic signed [FRAC_BITS+1:0]  o_r20,
    output logic signed [FRAC_BITS+1:0]  o_r21,
    output logic signed [FRAC_BITS+1:0]  o_r22,
    output logic signed [FRAC_BITS+2:0]  o_out_z1,
    output logic signed [FRAC_BITS+2:0]  o_out_x2,
    output logic signed [FRAC_BITS+2:0]  o_out_z3,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [15:0]                  i_cfg_data
);

    localparam int MW = FRAC_BITS + 2;
    localparam int SH = WF - FRAC_BITS;
    localparam int CW = (2 * MW + 1 > 32) ? 2 * MW + 1 : 32;
    localparam logic signed [MW-1:0] ONE_M = {2'b01, {FRAC_BITS{1'b0}}};

    logic w_en;
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // configuration
    logic [15:0] r_thr;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // front: gimbal test, clamp, radicand, lane setup
    logic signed [2*MW-1:0] w_sq20, w_sq21, w_c2;
    logic [2*MW:0]          w_sum;
    logic [31:0]            w_thr2;
    logic                   w_degen;
    logic signed [MW-1:0]   w_e22c;
    logic signed [31:0]     w_c;
    logic [SQ_RW-1:0]       w_n;
    t_q                     w_q02, w_q10, w_q11, w_q12, w_q20, w_q21;

    assign w_sq20  = i_m20 * i_m20;
    assign w_sq21  = i_m21 * i_m21;
    assign w_sum   = {1'b0, w_sq20} + {1'b0, w_sq21};
    assign w_thr2  = r_thr * r_thr;
    assign w_degen = !(CW'(w_sum) > CW'(w_thr2));

    assign w_e22c = (i_m22 > ONE_M) ? ONE_M : ((i_m22 < -ONE_M) ? -ONE_M : i_m22);
    assign w_c    = 32'(t_q'(w_e22c) <<< SH);
    assign w_c2   = w_e22c * w_e22c;
    assign w_n    = (SQ_RW'(1) << 60) - (SQ_RW'(unsigned'(w_c2)) << (2 * SH));

    assign w_q02 = t_q'(i_m02) <<< SH;
    assign w_q10 = t_q'(i_m10) <<< SH;
    assign w_q11 = t_q'(i_m11) <<< SH;
    assign w_q12 = t_q'(i_m12) <<< SH;
    assign w_q20 = t_q'(i_m20) <<< SH;
    assign w_q21 = t_q'(i_m21) <<< SH;

    logic r_f_valid;
    t_sq  r_f_item;
    t_sq  n_f_item;

    always_comb begin
        n_f_item.side.kind  = i_kind;
        n_f_item.side.degen = w_degen;
        n_f_item.side.a0    = AMW'(i_in_z1);
        n_f_item.side.a1    = AMW'(i_in_x2);
        n_f_item.side.a2    = AMW'(i_in_z3);
        n_f_item.rem        = w_n;
        n_f_item.root       = '0;
        n_f_item.c          = w_c;
        if (!i_kind) begin
            n_f_item.lane[0] = sincos_setup(t_q'(i_in_z1) <<< SH);
            n_f_item.lane[1] = sincos_setup(t_q'(i_in_x2) <<< SH);
            n_f_item.lane[2] = sincos_setup(t_q'(i_in_z3) <<< SH);
        end else begin
            n_f_item.lane[0] = w_degen ? atan2_setup(w_q10, w_q11)
                                       : atan2_setup(w_q02, -w_q12);
            n_f_item.lane[1] = atan2_setup('0, '0);  // replaced after the root
            n_f_item.lane[2] = atan2_setup(w_q20, w_q21);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_item <= n_f_item;
        end
    end

    // square root chain
    logic w_sq_valid [SQ_STEPS+1];
    t_sq  w_sq_item  [SQ_STEPS+1];

    assign w_sq_valid[0] = r_f_valid;
    assign w_sq_item[0]  = r_f_item;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        ezmc_sqrt_cell #(.BIT(SQ_STEPS - 1 - k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[k]),
            .i_item  (w_sq_item[k]),
            .o_valid (w_sq_valid[k+1]),
            .o_item  (w_sq_item[k+1])
        );
    end

    // acos lane: atan2(sqrt(1 - c^2), c)
    logic        r_p_valid;
    t_lane [2:0] r_p_lane;
    t_side       r_p_side;
    t_lane [2:0] n_p_lane;
    t_sq         w_last;

    assign w_last = w_sq_item[SQ_STEPS];

    always_comb begin
        n_p_lane = w_last.lane;
        if (w_last.side.kind && !w_last.side.degen) begin
            n_p_lane[1] = atan2_setup(t_q'({5'd0, w_last.root}), t_q'(w_last.c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid <= w_sq_valid[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_lane <= n_p_lane;
            r_p_side <= w_last.side;
        end
    end

    // CORDIC chain
    logic        w_cd_valid [CORDIC_STEPS+1];
    t_lane [2:0] w_cd_lane  [CORDIC_STEPS+1];
    t_side       w_cd_side  [CORDIC_STEPS+1];

    assign w_cd_valid[0] = r_p_valid;
    assign w_cd_lane[0]  = r_p_lane;
    assign w_cd_side[0]  = r_p_side;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        ezmc_cordic_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cd_valid[k]),
            .i_lane  (w_cd_lane[k]),
            .i_side  (w_cd_side[k]),
            .o_valid (w_cd_valid[k+1]),
            .o_lane  (w_cd_lane[k+1]),
            .o_side  (w_cd_side[k+1])
        );
    end

    ezmc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_cd_valid[CORDIC_STEPS]),
        .i_lane   (w_cd_lane[CORDIC_STEPS]),
        .i_side   (w_cd_side[CORDIC_STEPS]),
        .o_valid  (o_out_valid),
        .o_r00    (o_r00),
        .o_r01    (o_r01),
        .o_r02    (o_r02),
        .o_r10    (o_r10),
        .o_r11    (o_r11),
        .o_r12    (o_r12),
        .o_r20    (o_r20),
        .o_r21    (o_r21),
        .o_r22    (o_r22),
        .o_out_z1 (o_out_z1),
        .o_out_x2 (o_out_x2),
        .o_out_z3 (o_out_z3)
    );

    a_stall_only_on_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without a held result");

    a_accept_enters_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_f_valid)
        else $error("accepted transaction missing from the input stage");

    a_thr_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_thr == $past(i_cfg_data)))
        else $error("threshold write lost");

endmodule

`default_nettype wire
